[sv/aapl_pkg.sv]
// ----------------------------------------------------------------------------
// aapl_pkg
// Shared types and widths for the all-pairs box overlap filter.
// ----------------------------------------------------------------------------
package aapl_pkg;

    localparam int POS_W   = 24;
    localparam int SIZE_W  = 23;
    localparam int LAYER_W = 3;
    localparam int INDEX_W = 3;
    localparam int COUNT_W = 4;
    localparam int MASK_W  = 64;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic        [SIZE_W-1:0] size_x;
        logic        [SIZE_W-1:0] size_y;
        logic        [SIZE_W-1:0] size_z;
        logic        [LAYER_W-1:0] layer;
    } box_t;

    typedef struct packed {
        logic               load;
        logic               scan;
        logic [INDEX_W-1:0] idx;
        logic [COUNT_W-1:0] count;
    } cmd_ctl_t;

    typedef struct packed {
        cmd_ctl_t ctl;
        box_t     box;
    } cmd_t;

endpackage

[sv/aapl_if.sv]
// ----------------------------------------------------------------------------
// aapl_if
// Valid/ready channels: object input, pair output, layer mask write.
// ----------------------------------------------------------------------------
interface aapl_obj_if;
    logic                valid;
    logic                ready;
    logic signed [23:0]  pos_x;
    logic signed [23:0]  pos_y;
    logic signed [23:0]  pos_z;
    logic        [22:0]  size_x;
    logic        [22:0]  size_y;
    logic        [22:0]  size_z;
    logic        [2:0]   layer;
    logic                last_object;

    modport source (
        output valid, pos_x, pos_y, pos_z, size_x, size_y, size_z, layer, last_object,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, size_x, size_y, size_z, layer, last_object,
        output ready
    );
endinterface

interface aapl_pair_if;
    logic       valid;
    logic       ready;
    logic [2:0] first_index;
    logic [2:0] second_index;
    logic       pair_valid;
    logic       last;

    modport source (
        output valid, first_index, second_index, pair_valid, last,
        input  ready
    );
    modport sink (
        input  valid, first_index, second_index, pair_valid, last,
        output ready
    );
endinterface

interface aapl_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

[sv/aapl_front.sv]
// ----------------------------------------------------------------------------
// aapl_front
// Accepts objects, assigns store slots and issues load/scan commands.
// ----------------------------------------------------------------------------
module aapl_front #(
    parameter int MAX_OBJECTS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    aapl_obj_if.sink       obj,
    output logic           push_valid,
    input  logic           push_ready,
    output aapl_pkg::cmd_t push_cmd
);
    import aapl_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               keep;
    logic               accept;

    assign keep       = count_reg < COUNT_W'(MAX_OBJECTS);
    assign obj.ready  = push_ready;
    assign accept     = obj.valid && push_ready;
    // drop objects past capacity unless they close the set
    assign push_valid = obj.valid && (keep || obj.last_object);

    always_comb
    begin
        push_cmd.box.pos_x  = obj.pos_x;
        push_cmd.box.pos_y  = obj.pos_y;
        push_cmd.box.pos_z  = obj.pos_z;
        push_cmd.box.size_x = obj.size_x;
        push_cmd.box.size_y = obj.size_y;
        push_cmd.box.size_z = obj.size_z;
        push_cmd.box.layer  = obj.layer;
        push_cmd.ctl.load   = keep;
        push_cmd.ctl.scan   = obj.last_object;
        push_cmd.ctl.idx    = count_reg[INDEX_W-1:0];
        push_cmd.ctl.count  = keep ? count_reg + COUNT_W'(1) : count_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (obj.last_object)
                count_next = '0;
            else if (keep)
                count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

[sv/aapl_queue.sv]
// ----------------------------------------------------------------------------
// aapl_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module aapl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  aapl_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output aapl_pkg::cmd_t pop_cmd
);
    import aapl_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = fill_reg != 2'd2;
    assign pop_valid  = fill_reg != 2'd0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[sv/aapl_back.sv]
// ----------------------------------------------------------------------------
// aapl_back
// Holds the box store and the layer mask, scans all pairs, emits results.
// ----------------------------------------------------------------------------
module aapl_back #(
    parameter int MAX_OBJECTS = 8,
    parameter int NUM_LAYERS  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  aapl_pkg::cmd_t pop_cmd,
    aapl_cfg_if.sink       cfg,
    aapl_pair_if.source    pair
);
    import aapl_pkg::*;

    localparam int IDX_W  = $clog2(MAX_OBJECTS);
    localparam int SPAN_W = POS_W + 2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SPAN = 5'b00100,
        S_EVAL = 5'b01000,
        S_END  = 5'b10000
    } state_t;

    typedef struct packed {
        logic signed [SPAN_W-1:0] lo;
        logic signed [SPAN_W-1:0] hi;
    } span_t;

    function automatic span_t make_span(logic signed [POS_W-1:0] p,
                                        logic [SIZE_W-1:0] s);
        span_t                    r;
        logic signed [SPAN_W-1:0] c;
        logic signed [SPAN_W-1:0] h;
        c    = SPAN_W'(p) <<< 1;
        h    = $signed({3'b000, s});
        r.lo = c - h;
        r.hi = c + h;
        return r;
    endfunction

    function automatic logic touch(span_t a, span_t b);
        return (a.lo <= b.hi) && (a.hi >= b.lo);
    endfunction

    state_t             state_reg;
    state_t             state_next;
    logic [INDEX_W-1:0] i_reg;
    logic [INDEX_W-1:0] i_next;
    logic [INDEX_W-1:0] j_reg;
    logic [INDEX_W-1:0] j_next;
    logic [COUNT_W-1:0] n_reg;
    logic [COUNT_W-1:0] n_next;
    logic [MASK_W-1:0]  mask_reg;

    box_t  mem [MAX_OBJECTS];
    box_t  rd_a_reg;
    box_t  rd_b_reg;
    span_t ax_reg, ay_reg, az_reg;
    span_t bx_reg, by_reg, bz_reg;
    logic  layer_ok_reg;
    logic  layer_ok_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [INDEX_W-1:0] out_first_reg;
    logic [INDEX_W-1:0] out_second_reg;
    logic               out_pair_reg;
    logic               out_last_reg;
    logic               load_pair;
    logic               load_end;
    logic               slot_free;
    logic               hit;
    logic               do_pop;

    assign cfg.ready         = 1'b1;
    assign pair.valid        = out_valid_reg;
    assign pair.first_index  = out_first_reg;
    assign pair.second_index = out_second_reg;
    assign pair.pair_valid   = out_pair_reg;
    assign pair.last         = out_last_reg;

    assign pop_ready = state_reg == S_IDLE;
    assign do_pop    = pop_valid && pop_ready;
    assign slot_free = !out_valid_reg || pair.ready;

    assign layer_ok_next = (COUNT_W'(rd_a_reg.layer) < COUNT_W'(NUM_LAYERS))
                        && (COUNT_W'(rd_b_reg.layer) < COUNT_W'(NUM_LAYERS))
                        && mask_reg[{rd_a_reg.layer, rd_b_reg.layer}];

    assign hit = layer_ok_reg && touch(ax_reg, bx_reg) && touch(ay_reg, by_reg)
              && touch(az_reg, bz_reg);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        load_pair  = 1'b0;
        load_end   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (do_pop && pop_cmd.ctl.scan)
                begin
                    n_next = pop_cmd.ctl.count;
                    i_next = '0;
                    j_next = INDEX_W'(1);
                    state_next = (pop_cmd.ctl.count < COUNT_W'(2)) ? S_END : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!hit || slot_free)
                begin
                    load_pair = hit;
                    if (COUNT_W'(j_reg) + COUNT_W'(1) < n_reg)
                    begin
                        j_next     = j_reg + INDEX_W'(1);
                        state_next = S_READ;
                    end
                    else if (COUNT_W'(i_reg) + COUNT_W'(2) < n_reg)
                    begin
                        i_next     = i_reg + INDEX_W'(1);
                        j_next     = i_reg + INDEX_W'(2);
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_END;
                    end
                end
            end
            S_END:
            begin
                if (slot_free)
                begin
                    load_end   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pair.ready)
            out_valid_next = 1'b0;
        if (load_pair || load_end)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                mask_reg <= cfg.data;
        end
    end

    // store write and registered dual read
    always_ff @(posedge clk)
    begin
        if (do_pop && pop_cmd.ctl.load)
            mem[pop_cmd.ctl.idx[IDX_W-1:0]] <= pop_cmd.box;
        rd_a_reg <= mem[i_reg[IDX_W-1:0]];
        rd_b_reg <= mem[j_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        ax_reg       <= make_span(rd_a_reg.pos_x, rd_a_reg.size_x);
        ay_reg       <= make_span(rd_a_reg.pos_y, rd_a_reg.size_y);
        az_reg       <= make_span(rd_a_reg.pos_z, rd_a_reg.size_z);
        bx_reg       <= make_span(rd_b_reg.pos_x, rd_b_reg.size_x);
        by_reg       <= make_span(rd_b_reg.pos_y, rd_b_reg.size_y);
        bz_reg       <= make_span(rd_b_reg.pos_z, rd_b_reg.size_z);
        layer_ok_reg <= layer_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_pair)
        begin
            out_first_reg  <= i_reg;
            out_second_reg <= j_reg;
            out_pair_reg   <= 1'b1;
            out_last_reg   <= 1'b0;
        end
        else if (load_end)
        begin
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_pair_reg   <= 1'b0;
            out_last_reg   <= 1'b1;
        end
    end

endmodule

[sv/aabb_all_pairs_layer_filter_unit.sv]
// A load passes the command queue register into the store while the scanner idles;
// during a scan it waits in the 2-entry command queue, and the input stalls once it fills.
// Loads are taken one per cycle while the queue has room; each pair of a scan passes
// the read, span and compare states. The scan covers P = n(n-1)/2 pairs (28 for n = 8)
// before the end item; a result that waits on the output stalls the scan and end item.
// Reset clears count, queue, scan state, output valid and layer mask, not the box store.
// ----------------------------------------------------------------------------
// aabb_all_pairs_layer_filter_unit
// Top level: front classifier, command queue and pair scanner.
// ----------------------------------------------------------------------------
module aabb_all_pairs_layer_filter_unit #(
    parameter int MAX_OBJECTS = 8,
    parameter int NUM_LAYERS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    aapl_obj_if.sink    obj,
    aapl_cfg_if.sink    cfg,
    aapl_pair_if.source pair
);
    import aapl_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    aapl_front #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .obj        (obj),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    aapl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    aapl_back #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .NUM_LAYERS  (NUM_LAYERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .cfg       (cfg),
        .pair      (pair)
    );

endmodule
